// ----- rtl/qvt_pkg.sv -----
// shared types, constants and fixed-point helpers for the quaternion vertex transform
package qvt_pkg;

    localparam int WORD_BITS  = 32;
    localparam int FRAC_BITS  = 16;
    localparam int PROD_BITS  = 2 * WORD_BITS;
    localparam int Q_BITS     = PROD_BITS - FRAC_BITS;
    localparam int SUM_BITS   = WORD_BITS + 2;
    localparam int COLOR_BITS = 32;
    localparam int NUM_FIELDS = 9;
    localparam int TDATA_BITS = NUM_FIELDS * WORD_BITS;
    localparam int LANE_DEPTH = 4;
    localparam int PIPE_DEPTH = LANE_DEPTH + 1;
    localparam int CFG_IDX_BITS = 3;

    typedef logic signed [WORD_BITS-1:0] word_t;
    typedef logic signed [SUM_BITS-1:0]  sum_t;
    typedef logic signed [Q_BITS-1:0]    q_t;

    localparam word_t WORD_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
    localparam word_t WORD_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};
    localparam word_t ONE_Q    = word_t'(1) <<< FRAC_BITS;

    // configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] REG_POS_X = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_POS_Y = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_POS_Z = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_ROT_X = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_ROT_Y = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] REG_ROT_Z = 3'd5;
    localparam logic [CFG_IDX_BITS-1:0] REG_ROT_W = 3'd6;
    localparam logic [CFG_IDX_BITS-1:0] REG_SCALE = 3'd7;

    typedef struct packed {
        word_t z;
        word_t y;
        word_t x;
    } vec3_t;

    typedef struct packed {
        word_t w;
        word_t z;
        word_t y;
        word_t x;
    } quat_t;

    typedef struct packed {
        logic [COLOR_BITS-1:0] blue;
        logic [COLOR_BITS-1:0] green;
        logic [COLOR_BITS-1:0] red;
    } color_t;

    typedef struct packed {
        color_t color;
        vec3_t  nrm;
        vec3_t  pos;
    } result_t;

    function automatic word_t sat_q(input q_t x);
        logic [Q_BITS-WORD_BITS:0] top;
        top = x[Q_BITS-1:WORD_BITS-1];
        if ((&top) || !(|top)) begin
            return x[WORD_BITS-1:0];
        end else if (x[Q_BITS-1]) begin
            return WORD_MIN;
        end else begin
            return WORD_MAX;
        end
    endfunction

    function automatic word_t sat_s(input sum_t x);
        logic [SUM_BITS-WORD_BITS:0] top;
        top = x[SUM_BITS-1:WORD_BITS-1];
        if ((&top) || !(|top)) begin
            return x[WORD_BITS-1:0];
        end else if (x[SUM_BITS-1]) begin
            return WORD_MIN;
        end else begin
            return WORD_MAX;
        end
    endfunction

    // full product, floor shift by the fraction width, saturate
    function automatic word_t qmul(input word_t a, input word_t b);
        logic signed [PROD_BITS-1:0] p;
        p = a * b;
        return sat_q(p[PROD_BITS-1:FRAC_BITS]);
    endfunction

endpackage

// ----- rtl/qvt_rot_lane.sv -----
// one rotation lane: t = v x r - w v, then v + 2 (t x r), four register stages
module qvt_rot_lane (
    input  logic           aclk,
    input  logic           ce,
    input  qvt_pkg::vec3_t vin,
    input  qvt_pkg::quat_t rot,
    output qvt_pkg::vec3_t vout
);

    qvt_pkg::word_t prod_reg [9];
    qvt_pkg::word_t prod_next [9];
    qvt_pkg::word_t cp_reg [6];
    qvt_pkg::word_t cp_next [6];
    qvt_pkg::vec3_t t_reg, t_next;
    qvt_pkg::vec3_t o_reg, o_next;
    qvt_pkg::vec3_t v1_reg, v2_reg, v3_reg;

    function automatic qvt_pkg::word_t tsum(input qvt_pkg::word_t a, input qvt_pkg::word_t b,
                                            input qvt_pkg::word_t c);
        return qvt_pkg::sat_s(qvt_pkg::sum_t'(a) - qvt_pkg::sum_t'(b) - qvt_pkg::sum_t'(c));
    endfunction

    // c = a - b, then v + 2c, each step saturated
    function automatic qvt_pkg::word_t finish(input qvt_pkg::word_t v, input qvt_pkg::word_t a,
                                              input qvt_pkg::word_t b);
        qvt_pkg::word_t c;
        qvt_pkg::word_t d;
        c = qvt_pkg::sat_s(qvt_pkg::sum_t'(a) - qvt_pkg::sum_t'(b));
        d = qvt_pkg::sat_s(qvt_pkg::sum_t'(c) + qvt_pkg::sum_t'(c));
        return qvt_pkg::sat_s(qvt_pkg::sum_t'(v) + qvt_pkg::sum_t'(d));
    endfunction

    always_comb begin
        prod_next[0] = qvt_pkg::qmul(vin.y, rot.z);
        prod_next[1] = qvt_pkg::qmul(rot.y, vin.z);
        prod_next[2] = qvt_pkg::qmul(rot.w, vin.x);
        prod_next[3] = qvt_pkg::qmul(rot.x, vin.z);
        prod_next[4] = qvt_pkg::qmul(vin.x, rot.z);
        prod_next[5] = qvt_pkg::qmul(rot.w, vin.y);
        prod_next[6] = qvt_pkg::qmul(vin.x, rot.y);
        prod_next[7] = qvt_pkg::qmul(rot.x, vin.y);
        prod_next[8] = qvt_pkg::qmul(rot.w, vin.z);

        t_next.x = tsum(prod_reg[0], prod_reg[1], prod_reg[2]);
        t_next.y = tsum(prod_reg[3], prod_reg[4], prod_reg[5]);
        t_next.z = tsum(prod_reg[6], prod_reg[7], prod_reg[8]);

        cp_next[0] = qvt_pkg::qmul(t_reg.y, rot.z);
        cp_next[1] = qvt_pkg::qmul(rot.y, t_reg.z);
        cp_next[2] = qvt_pkg::qmul(rot.x, t_reg.z);
        cp_next[3] = qvt_pkg::qmul(t_reg.x, rot.z);
        cp_next[4] = qvt_pkg::qmul(t_reg.x, rot.y);
        cp_next[5] = qvt_pkg::qmul(rot.x, t_reg.y);

        o_next.x = finish(v3_reg.x, cp_reg[0], cp_reg[1]);
        o_next.y = finish(v3_reg.y, cp_reg[2], cp_reg[3]);
        o_next.z = finish(v3_reg.z, cp_reg[4], cp_reg[5]);
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            prod_reg <= prod_next;
            t_reg    <= t_next;
            cp_reg   <= cp_next;
            o_reg    <= o_next;
            v1_reg   <= vin;
            v2_reg   <= v1_reg;
            v3_reg   <= v2_reg;
        end
    end

    assign vout = o_reg;

endmodule

// ----- rtl/qvt_merge.sv -----
// merging stage: scales and translates the position lane, joins normal lane and colour
module qvt_merge (
    input  logic             aclk,
    input  logic             ce,
    input  qvt_pkg::vec3_t   pos_in,
    input  qvt_pkg::vec3_t   nrm_in,
    input  qvt_pkg::color_t  color_in,
    input  qvt_pkg::word_t   scale,
    input  qvt_pkg::vec3_t   trans,
    output qvt_pkg::result_t res
);

    qvt_pkg::vec3_t  sp_reg, sp_next;
    qvt_pkg::vec3_t  nrm_reg;
    qvt_pkg::color_t color_reg;

    always_comb begin
        sp_next.x = qvt_pkg::qmul(pos_in.x, scale);
        sp_next.y = qvt_pkg::qmul(pos_in.y, scale);
        sp_next.z = qvt_pkg::qmul(pos_in.z, scale);
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            sp_reg    <= sp_next;
            nrm_reg   <= nrm_in;
            color_reg <= color_in;
        end
    end

    always_comb begin
        res.pos.x = qvt_pkg::sat_s(qvt_pkg::sum_t'(trans.x) + qvt_pkg::sum_t'(sp_reg.x));
        res.pos.y = qvt_pkg::sat_s(qvt_pkg::sum_t'(trans.y) + qvt_pkg::sum_t'(sp_reg.y));
        res.pos.z = qvt_pkg::sat_s(qvt_pkg::sum_t'(trans.z) + qvt_pkg::sum_t'(sp_reg.z));
        res.nrm   = nrm_reg;
        res.color = color_reg;
    end

endmodule

// ----- rtl/quaternion_vertex_transform_top.sv -----
// top level: config registers, two rotation lanes, merge stage and output skid buffer
// an accepted input transaction passes 4 lane stages, one merge stage and the output register
// on its way to m_tvalid; throughput one vertex per cycle while the skid is empty, set by the
// fully pipelined multipliers in each lane. s_tready drops only while the skid holds a result.
// reset (aresetn low, synchronous) empties the pipeline and restores identity transform.
module quaternion_vertex_transform_top (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // vx, vy, vz, nx, ny, nz, red, green, blue, 32 bits each from bit 0 up
    input  logic [qvt_pkg::TDATA_BITS-1:0]     s_tdata,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // vx, vy, vz, nx, ny, nz, red, green, blue, 32 bits each from bit 0 up
    output logic [qvt_pkg::TDATA_BITS-1:0]     m_tdata,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [qvt_pkg::CFG_IDX_BITS-1:0]   cfg_index,
    input  logic [qvt_pkg::WORD_BITS-1:0]      cfg_data
);

    localparam int W = qvt_pkg::WORD_BITS;

    qvt_pkg::vec3_t   pos_reg;
    qvt_pkg::quat_t   rot_reg;
    qvt_pkg::word_t   scale_reg;

    logic [qvt_pkg::PIPE_DEPTH-1:0] vld_reg;
    qvt_pkg::color_t  color_reg [qvt_pkg::LANE_DEPTH];
    logic             skid_valid_reg;
    qvt_pkg::result_t skid_reg;
    logic             out_valid_reg;
    qvt_pkg::result_t out_reg;

    logic             ce;
    logic             in_fire;
    qvt_pkg::vec3_t   vin, nin;
    qvt_pkg::color_t  cin;
    qvt_pkg::vec3_t   vrot, nrot;
    qvt_pkg::result_t fin;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg   <= '0;
            rot_reg   <= '{w: qvt_pkg::ONE_Q, default: '0};
            scale_reg <= qvt_pkg::ONE_Q;
        end else if (cfg_valid) begin
            case (cfg_index)
                qvt_pkg::REG_POS_X: pos_reg.x <= cfg_data;
                qvt_pkg::REG_POS_Y: pos_reg.y <= cfg_data;
                qvt_pkg::REG_POS_Z: pos_reg.z <= cfg_data;
                qvt_pkg::REG_ROT_X: rot_reg.x <= cfg_data;
                qvt_pkg::REG_ROT_Y: rot_reg.y <= cfg_data;
                qvt_pkg::REG_ROT_Z: rot_reg.z <= cfg_data;
                qvt_pkg::REG_ROT_W: rot_reg.w <= cfg_data;
                qvt_pkg::REG_SCALE: scale_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // pipeline runs while the skid is free; a stalled output result parks there
    assign ce       = !skid_valid_reg;
    assign s_tready = ce;
    assign in_fire  = s_tvalid && s_tready;

    always_comb begin
        vin.x     = s_tdata[0*W +: W];
        vin.y     = s_tdata[1*W +: W];
        vin.z     = s_tdata[2*W +: W];
        nin.x     = s_tdata[3*W +: W];
        nin.y     = s_tdata[4*W +: W];
        nin.z     = s_tdata[5*W +: W];
        cin.red   = s_tdata[6*W +: W];
        cin.green = s_tdata[7*W +: W];
        cin.blue  = s_tdata[8*W +: W];
    end

    qvt_rot_lane u_pos_lane (
        .aclk (aclk),
        .ce   (ce),
        .vin  (vin),
        .rot  (rot_reg),
        .vout (vrot)
    );

    qvt_rot_lane u_nrm_lane (
        .aclk (aclk),
        .ce   (ce),
        .vin  (nin),
        .rot  (rot_reg),
        .vout (nrot)
    );

    qvt_merge u_merge (
        .aclk     (aclk),
        .ce       (ce),
        .pos_in   (vrot),
        .nrm_in   (nrot),
        .color_in (color_reg[qvt_pkg::LANE_DEPTH-1]),
        .scale    (scale_reg),
        .trans    (pos_reg),
        .res      (fin)
    );

    always_ff @(posedge aclk) begin
        if (ce) begin
            color_reg[0] <= cin;
            for (int i = 1; i < qvt_pkg::LANE_DEPTH; i++) begin
                color_reg[i] <= color_reg[i-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg        <= '0;
            skid_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else if (skid_valid_reg) begin
            if (m_tready) begin
                out_reg        <= skid_reg;
                skid_valid_reg <= 1'b0;
            end
        end else begin
            vld_reg <= {vld_reg[qvt_pkg::PIPE_DEPTH-2:0], in_fire};
            if (vld_reg[qvt_pkg::PIPE_DEPTH-1]) begin
                if (!out_valid_reg || m_tready) begin
                    out_reg       <= fin;
                    out_valid_reg <= 1'b1;
                end else begin
                    skid_reg       <= fin;
                    skid_valid_reg <= 1'b1;
                end
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_reg.color.blue, out_reg.color.green, out_reg.color.red,
                       out_reg.nrm.z, out_reg.nrm.y, out_reg.nrm.x,
                       out_reg.pos.z, out_reg.pos.y, out_reg.pos.x};

`ifndef SYNTHESIS
    a_skid_implies_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid holds a result while the output register is empty");

    a_skid_drains: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg && m_tready |=> !skid_valid_reg && out_valid_reg)
        else $error("skid did not drain into the output register");

    a_stall_parks: assert property (@(posedge aclk) disable iff (!aresetn)
        vld_reg[qvt_pkg::PIPE_DEPTH-1] && !skid_valid_reg && out_valid_reg && !m_tready
        |=> skid_valid_reg)
        else $error("finished result lost while the output was stalled");
`endif

endmodule
